FILE: hdl/uniform_grid_neighbour_search_top_defines.svh
// ----------------------------------------------------------------------------
// uniform grid neighbour search assertion macros
// shared assertion forms for the grid search top level
// ----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH
`define UNIFORM_GRID_NEIGHBOUR_SEARCH_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define UGNS_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UGNS_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ugns_pkg.sv
// ----------------------------------------------------------------------------
// ugns_pkg
// types, constants and helpers for the uniform grid neighbour search
// ----------------------------------------------------------------------------
package ugns_pkg;
	localparam int MaxCellsPerAxisDef = 8;
	localparam int CellSlotsDef = 16;
	localparam int MaxNeighboursDef = 64;
	localparam int IdBitsDef = 12;

	localparam int PosW = 24;
	localparam int CsW = 20;
	localparam int DimW = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 20;
	localparam int QuotW = 24;
	localparam int DistW = 52;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_RADIUS = 2'd2,
		KIND_LIST   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OUT   = 2'd1,
		ST_FULL  = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_CELL_SIZE = 2'd0,
		REG_COLUMNS   = 2'd1,
		REG_ROWS      = 2'd2,
		REG_LAYERS    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_DECODE,
		S_CLEAR,
		S_CELL,
		S_FILL,
		S_SLOT_RD,
		S_SLOT_WAIT,
		S_DIST,
		S_SUM,
		S_CMP,
		S_FLUSH,
		S_WRITE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic clr_start;
		logic cell_first;
		logic cell_next;
		logic fill_rd;
		logic slot_first;
		logic slot_rd;
		logic slot_next;
		logic dist_s1;
		logic dist_s2;
		logic dist_s3;
		logic do_insert;
		logic emit_match;
		logic emit_final;
		logic [1:0] final_status;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic clr_done;
		logic in_grid;
		logic cell_full;
		logic cell_ok;
		logic cell_last;
		logic slot_valid;
		logic match;
		logic any_out;
		logic trunc;
	} stat_t;

	function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] r,
		input logic [DimW-1:0] mx);
		eff_dim = (r > mx) ? mx : r;
	endfunction
endpackage

FILE: hdl/ugns_div.sv
// ----------------------------------------------------------------------------
// ugns_div
// bit-serial unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ugns_div
	import ugns_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [QuotW-1:0]    dividend,
	input  logic [CsW-1:0]      divisor,
	output logic                done,
	output logic [QuotW-1:0]    quotient
);
	localparam int CntW = $clog2(QuotW + 1);

	logic [QuotW-1:0] quo_q;
	logic [CsW:0]     rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic [CsW:0]     trial;

	assign trial = {rem_q[CsW-1:0], quo_q[QuotW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(QuotW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				quo_q <= {quo_q[QuotW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QuotW-2:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q && !start;
	assign quotient = quo_q;
endmodule

FILE: hdl/ugns_datapath.sv
// ----------------------------------------------------------------------------
// ugns_datapath
// cell index, fill and slot stores, distance test and result formatting
// ----------------------------------------------------------------------------
module ugns_datapath
	import ugns_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = MaxCellsPerAxisDef,
	parameter int CELL_SLOTS         = CellSlotsDef,
	parameter int MAX_NEIGHBOURS     = MaxNeighboursDef,
	parameter int ID_BITS            = IdBitsDef
)(
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_t                     ctrl,
	output stat_t                     stat,
	input  logic [1:0]                kind,
	input  logic [ID_BITS-1:0]        particle_id,
	input  logic signed [PosW-1:0]    pos_x,
	input  logic signed [PosW-1:0]    pos_y,
	input  logic signed [PosW-1:0]    pos_z,
	input  logic [CsW-1:0]            cell_size_q,
	input  logic [DimW-1:0]           cols_q,
	input  logic [DimW-1:0]           rows_q,
	input  logic [DimW-1:0]           layers_q,
	output logic                      found,
	output logic [ID_BITS-1:0]        neighbour_id,
	output logic [1:0]                status,
	output logic                      last,
	output logic                      strobe
);
	localparam int AxW    = $clog2(MAX_CELLS_PER_AXIS);
	localparam int CellW  = 3 * AxW;
	localparam int NCells = 2 ** CellW;
	localparam int SlotW  = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
	localparam int FillW  = $clog2(CELL_SLOTS + 1);
	localparam int NSlots = NCells * (2 ** SlotW);
	localparam int AddrW  = CellW + SlotW;
	localparam int CntW   = $clog2(MAX_NEIGHBOURS + 1);
	localparam int CiW    = QuotW + 2;
	localparam logic [DimW-1:0] MaxDim =
		DimW'((MAX_CELLS_PER_AXIS < 2 ** DimW) ? MAX_CELLS_PER_AXIS : 2 ** DimW - 1);

	// item latch
	logic [1:0]               kind_q;
	logic [ID_BITS-1:0]       pid_q;
	logic signed [PosW-1:0]   px_q, py_q, pz_q;
	logic [CsW-1:0]           cs_eff;
	logic [1:0]               axis_q;
	logic signed [CiW-1:0]    ci_q [3];

	assign cs_eff = (cell_size_q == '0) ? CsW'(1) : cell_size_q;

	// divider shared by the three axes
	logic             div_done;
	logic [QuotW-1:0] quot;
	logic [QuotW-1:0] div_in;
	logic signed [PosW-1:0] cur_pos;
	logic             div_go;
	logic             div_busy_q;

	always_comb begin
		case (axis_q)
			2'd0:    cur_pos = px_q;
			2'd1:    cur_pos = py_q;
			default: cur_pos = pz_q;
		endcase
		div_in = cur_pos[PosW-1] ? QuotW'(-cur_pos) : QuotW'(cur_pos);
	end

	logic go_q;
	assign div_go = go_q;

	ugns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_in),
		.divisor  (cs_eff),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q       <= 1'b0;
			div_busy_q <= 1'b0;
			axis_q     <= '0;
		end else begin
			go_q <= 1'b0;
			if (ctrl.div_start) begin
				axis_q     <= '0;
				go_q       <= 1'b1;
				div_busy_q <= 1'b1;
			end else if (div_busy_q && !go_q && div_done) begin
				if (axis_q == 2'd2) div_busy_q <= 1'b0;
				else begin
					axis_q <= axis_q + 2'd1;
					go_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			kind_q <= kind;
			pid_q  <= particle_id;
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
		end
		if (div_busy_q && !go_q && div_done)
			ci_q[axis_q] <= cur_pos[PosW-1] ? -CiW'({2'b0, quot}) : CiW'({2'b0, quot});
	end

	assign stat.div_done = !div_busy_q;

	// neighbour cell walk
	logic [1:0] off_q [3];
	logic signed [CiW-1:0] nc [3];
	logic [DimW-1:0] dims [3];
	logic cell_in;
	logic [CellW-1:0] cell_addr;

	assign dims[0] = eff_dim(cols_q, MaxDim);
	assign dims[1] = eff_dim(rows_q, MaxDim);
	assign dims[2] = eff_dim(layers_q, MaxDim);

	always_comb begin
		cell_in = 1'b1;
		for (int a = 0; a < 3; a++) begin
			nc[a] = ci_q[a] + CiW'(off_q[a]) - CiW'(1);
			if (nc[a] < 0 || nc[a] >= $signed({{(CiW-DimW){1'b0}}, dims[a]}))
				cell_in = 1'b0;
		end
		cell_addr = {nc[0][AxW-1:0], nc[1][AxW-1:0], nc[2][AxW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (ctrl.cell_first) begin
			if (kind_q == KIND_RADIUS) begin
				off_q[0] <= 2'd0; off_q[1] <= 2'd0; off_q[2] <= 2'd0;
			end else begin
				off_q[0] <= 2'd1; off_q[1] <= 2'd1; off_q[2] <= 2'd1;
			end
		end else if (ctrl.cell_next) begin
			if (off_q[2] != 2'd2) off_q[2] <= off_q[2] + 2'd1;
			else begin
				off_q[2] <= 2'd0;
				if (off_q[1] != 2'd2) off_q[1] <= off_q[1] + 2'd1;
				else begin
					off_q[1] <= 2'd0;
					off_q[0] <= off_q[0] + 2'd1;
				end
			end
		end
	end

	assign stat.cell_ok   = cell_in;
	assign stat.in_grid   = cell_in;
	assign stat.cell_last = (kind_q != KIND_RADIUS) ||
		(off_q[0] == 2'd2 && off_q[1] == 2'd2 && off_q[2] == 2'd2);

	// fill count memory with a clearing sweep
	logic [FillW-1:0] fill_mem [NCells];
	logic [FillW-1:0] fill_rd_q;
	logic [CellW-1:0] cur_cell_q;
	logic [CellW:0]   clr_cnt_q;
	logic             clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (ctrl.clr_start) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (CellW+1)'(NCells - 1)) clr_busy_q <= 1'b0;
		end
	end

	assign stat.clr_done = !clr_busy_q;

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			fill_mem[clr_cnt_q[CellW-1:0]] <= '0;
		else if (ctrl.do_insert)
			fill_mem[cur_cell_q] <= fill_rd_q + 1'b1;
		if (ctrl.fill_rd) begin
			fill_rd_q  <= fill_mem[cell_addr];
			cur_cell_q <= cell_addr;
		end
	end

	assign stat.cell_full = fill_rd_q >= FillW'(CELL_SLOTS);

	// slot stores
	logic [ID_BITS-1:0]   mem_id [NSlots];
	logic [PosW-1:0]      mem_x  [NSlots];
	logic [PosW-1:0]      mem_y  [NSlots];
	logic [PosW-1:0]      mem_z  [NSlots];
	logic [FillW-1:0]     slot_q;
	logic [ID_BITS-1:0]   rd_id_q;
	logic signed [PosW-1:0] rd_x_q, rd_y_q, rd_z_q;
	logic [AddrW-1:0]     wr_addr, rd_addr;

	assign wr_addr = {cur_cell_q, fill_rd_q[SlotW-1:0]};
	assign rd_addr = {cur_cell_q, slot_q[SlotW-1:0]};

	always_ff @(posedge clk) begin
		if (ctrl.slot_first) slot_q <= '0;
		else if (ctrl.slot_next) slot_q <= slot_q + 1'b1;
		if (ctrl.do_insert) begin
			mem_id[wr_addr] <= pid_q;
			mem_x[wr_addr]  <= px_q;
			mem_y[wr_addr]  <= py_q;
			mem_z[wr_addr]  <= pz_q;
		end
		if (ctrl.slot_rd) begin
			rd_id_q <= mem_id[rd_addr];
			rd_x_q  <= mem_x[rd_addr];
			rd_y_q  <= mem_y[rd_addr];
			rd_z_q  <= mem_z[rd_addr];
		end
	end

	assign stat.slot_valid = (slot_q < fill_rd_q) && (slot_q < FillW'(CELL_SLOTS));

	// distance: differences, squares, sum, compare
	logic signed [PosW:0]  dx_s1, dy_s1, dz_s1;
	logic [2*PosW+1:0]     sx_s2, sy_s2, sz_s2;
	logic [DistW-1:0]      d2_s3;
	logic [2*CsW-1:0]      h2_q;
	logic                  id_eq_s1;

	always_ff @(posedge clk) begin
		h2_q <= cs_eff * cs_eff;
		if (ctrl.dist_s1) begin
			dx_s1    <= (PosW+1)'(px_q) - (PosW+1)'(rd_x_q);
			dy_s1    <= (PosW+1)'(py_q) - (PosW+1)'(rd_y_q);
			dz_s1    <= (PosW+1)'(pz_q) - (PosW+1)'(rd_z_q);
			id_eq_s1 <= rd_id_q == pid_q;
		end
		if (ctrl.dist_s2) begin
			sx_s2 <= (2*PosW+2)'(dx_s1 * dx_s1);
			sy_s2 <= (2*PosW+2)'(dy_s1 * dy_s1);
			sz_s2 <= (2*PosW+2)'(dz_s1 * dz_s1);
		end
		if (ctrl.dist_s3)
			d2_s3 <= DistW'(sx_s2) + DistW'(sy_s2) + DistW'(sz_s2);
	end

	assign stat.match = (kind_q == KIND_LIST) ||
		(!id_eq_s1 && d2_s3 < DistW'(h2_q));

	// result counter and one-deep hold for the pending match
	logic [CntW-1:0]    cnt_q;
	logic               trunc_q;
	logic               pend_q;
	logic [ID_BITS-1:0] pend_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			trunc_q <= 1'b0;
			pend_q  <= 1'b0;
			strobe  <= 1'b0;
			found   <= 1'b0;
			last    <= 1'b0;
			status  <= '0;
			neighbour_id <= '0;
		end else begin
			strobe <= 1'b0;
			if (ctrl.load) begin
				cnt_q   <= '0;
				trunc_q <= 1'b0;
				pend_q  <= 1'b0;
			end else if (ctrl.emit_match) begin
				if (cnt_q < CntW'(MAX_NEIGHBOURS)) begin
					cnt_q     <= cnt_q + 1'b1;
					pend_q    <= 1'b1;
					pend_id_q <= rd_id_q;
					if (pend_q) begin
						strobe <= 1'b1; found <= 1'b1; last <= 1'b0;
						status <= ST_OK; neighbour_id <= pend_id_q;
					end
				end else trunc_q <= 1'b1;
			end else if (ctrl.emit_final) begin
				strobe <= 1'b1;
				last   <= 1'b1;
				pend_q <= 1'b0;
				if (pend_q) begin
					found <= 1'b1; neighbour_id <= pend_id_q;
					status <= trunc_q ? ST_TRUNC : ST_OK;
				end else begin
					found <= 1'b0; neighbour_id <= '0;
					status <= ctrl.final_status;
				end
			end
		end
	end

	assign stat.any_out = pend_q;
	assign stat.trunc   = trunc_q;
endmodule

FILE: hdl/ugns_ctrl.sv
// ----------------------------------------------------------------------------
// ugns_ctrl
// sequencer for clear, insert and the two query walks
// ----------------------------------------------------------------------------
module ugns_ctrl
	import ugns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  stat_t      stat,
	output ctrl_t      ctrl,
	output logic       busy
);
	state_t state_q, state_d;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) kind_q <= kind;
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = !stat.clr_done;
				if (start && stat.clr_done) begin
					ctrl.load = 1'b1;
					if (kind == KIND_CLEAR) begin
						ctrl.clr_start = 1'b1;
						state_d = S_CLEAR;
					end else begin
						ctrl.div_start = 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_DIV: if (stat.div_done) begin
				ctrl.cell_first = 1'b1;
				state_d = S_DECODE;
			end
			S_CLEAR: begin
				ctrl.emit_final = 1'b1;
				ctrl.final_status = ST_OK;
				state_d = S_IDLE;
			end
			S_DECODE: begin
				if (kind_q != KIND_RADIUS && !stat.cell_ok) begin
					ctrl.emit_final = 1'b1;
					ctrl.final_status = ST_OUT;
					state_d = S_IDLE;
				end else state_d = S_CELL;
			end
			S_CELL: begin
				if (stat.cell_ok) begin
					ctrl.fill_rd = 1'b1;
					state_d = S_FILL;
				end else if (stat.cell_last) state_d = S_FLUSH;
				else ctrl.cell_next = 1'b1;
			end
			S_FILL: begin
				ctrl.slot_first = 1'b1;
				if (kind_q == KIND_INSERT) begin
					if (stat.cell_full) begin
						ctrl.emit_final = 1'b1;
						ctrl.final_status = ST_FULL;
						state_d = S_IDLE;
					end else state_d = S_WRITE;
				end else state_d = S_SLOT_RD;
			end
			S_WRITE: begin
				ctrl.do_insert = 1'b1;
				ctrl.emit_final = 1'b1;
				ctrl.final_status = ST_OK;
				state_d = S_IDLE;
			end
			S_SLOT_RD: begin
				if (stat.slot_valid) begin
					ctrl.slot_rd = 1'b1;
					state_d = S_SLOT_WAIT;
				end else if (stat.cell_last) state_d = S_FLUSH;
				else begin
					ctrl.cell_next = 1'b1;
					state_d = S_CELL;
				end
			end
			S_SLOT_WAIT: begin
				ctrl.dist_s1 = 1'b1;
				state_d = S_DIST;
			end
			S_DIST: begin
				ctrl.dist_s2 = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				ctrl.dist_s3 = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				ctrl.emit_match = stat.match;
				ctrl.slot_next = 1'b1;
				state_d = S_SLOT_RD;
			end
			S_FLUSH: begin
				ctrl.emit_final = 1'b1;
				ctrl.final_status = ST_OK;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: hdl/uniform_grid_neighbour_search_top.sv
// ----------------------------------------------------------------------------
// uniform_grid_neighbour_search_top
// 3d uniform grid cell lists with insert, clear and neighbour queries
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// item      in         start & !busy          kind, particle_id, pos_x/y/z
// result    out        strobe (no stall)      found, neighbour_id, status, last
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// one item at a time; an insert, radius or list item starts with three
// divisions, one per axis; a radius query then visits the slots of up to 27
// cells and a listing those of its own cell, while an insert writes its own cell
// after reset, and after a clear transaction, a sweep over every fill count
// zeroes the fill counts while busy is high
// results appear one per strobe and cannot be stalled by the receiver
`include "uniform_grid_neighbour_search_top_defines.svh"

module uniform_grid_neighbour_search_top
	import ugns_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = MaxCellsPerAxisDef,
	parameter int CELL_SLOTS         = CellSlotsDef,
	parameter int MAX_NEIGHBOURS     = MaxNeighboursDef,
	parameter int ID_BITS            = IdBitsDef
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             kind,
	input  logic [ID_BITS-1:0]     particle_id,
	input  logic signed [PosW-1:0] pos_x,
	input  logic signed [PosW-1:0] pos_y,
	input  logic signed [PosW-1:0] pos_z,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data,
	output logic                   strobe,
	output logic                   found,
	output logic [ID_BITS-1:0]     neighbour_id,
	output logic [1:0]             status,
	output logic                   last
);
	ctrl_t ctrl;
	stat_t stat;

	// configuration registers
	logic [CsW-1:0]  cell_size_q;
	logic [DimW-1:0] cols_q, rows_q, layers_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CsW'(5120);
			cols_q      <= DimW'(8);
			rows_q      <= DimW'(8);
			layers_q    <= DimW'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CELL_SIZE: cell_size_q <= cfg_data[CsW-1:0];
				REG_COLUMNS:   cols_q      <= cfg_data[DimW-1:0];
				REG_ROWS:      rows_q      <= cfg_data[DimW-1:0];
				REG_LAYERS:    layers_q    <= cfg_data[DimW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	ugns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// stores, distance unit and result register
	ugns_datapath #(
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
		.CELL_SLOTS         (CELL_SLOTS),
		.MAX_NEIGHBOURS     (MAX_NEIGHBOURS),
		.ID_BITS            (ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.kind         (kind),
		.particle_id  (particle_id),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.cell_size_q  (cell_size_q),
		.cols_q       (cols_q),
		.rows_q       (rows_q),
		.layers_q     (layers_q),
		.found        (found),
		.neighbour_id (neighbour_id),
		.status       (status),
		.last         (last),
		.strobe       (strobe)
	);

	// an accepted transaction must not start while a fill sweep runs
	`UGNS_ASSERT_IMPL(a_no_start_in_sweep, clk, arst_n, ctrl.load, stat.clr_done,
		"item accepted during fill sweep")
	// the final result always returns the block to idle
	`UGNS_ASSERT_NEXT(a_last_idle, clk, arst_n, ctrl.emit_final, !busy || !stat.clr_done,
		"block not idle after final result")
	// a result with no particle never carries a nonzero id
	`UGNS_ASSERT_IMPL(a_id_zero, clk, arst_n, strobe && !found, neighbour_id == '0,
		"id set on empty result")
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the uniform grid neighbour search against a behavioral grid model
// in the scoreboard: inserts, clears, radius and own cell queries under
// several grid settings, with bursty input traffic and random gaps
// ----------------------------------------------------------------------------
module tb_top;
	import ugns_pkg::*;

	localparam int SIDE      = 8;
	localparam int SLOTS     = 16;
	localparam int MAX_HITS  = 64;
	localparam int NCELLS    = SIDE * SIDE * SIDE;
	localparam int LIMIT     = 4000000;
	localparam int SETTLE    = 700;

	// expected result of one output strobe
	typedef struct {
		logic        found;
		logic [11:0] id;
		status_t     status;
		logic        last;
	} grid_result_t;

	// grid model and queue of pending results
	class grid_scoreboard;
		longint      cell_size;
		int          columns, rows, layers;
		int          fill[NCELLS];
		logic [11:0] slot_id[NCELLS*SLOTS];
		longint      slot_x[NCELLS*SLOTS];
		longint      slot_y[NCELLS*SLOTS];
		longint      slot_z[NCELLS*SLOTS];
		grid_result_t pending_q[$];
		int          errors;
		int          n_items;
		int          n_results;
		int          n_hits;
		int          n_trunc;
		int          n_full;
		int          n_out;

		function new();
			cell_size = 5120;
			columns = 8;
			rows = 8;
			layers = 8;
			foreach (fill[c]) fill[c] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [19:0] v);
			case (idx)
				REG_CELL_SIZE: cell_size = v;
				REG_COLUMNS: columns = v[3:0];
				REG_ROWS: rows = v[3:0];
				default: layers = v[3:0];
			endcase
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function bit inside_grid(longint i, longint j, longint k);
			int dc, dr, dl;
			dc = (columns > SIDE) ? SIDE : columns;
			dr = (rows > SIDE) ? SIDE : rows;
			dl = (layers > SIDE) ? SIDE : layers;
			return i >= 0 && i < dc && j >= 0 && j < dr && k >= 0 && k < dl;
		endfunction

		function void push(logic f, logic [11:0] id, status_t st, logic l);
			grid_result_t r;
			r.found = f;
			r.id = id;
			r.status = st;
			r.last = l;
			pending_q.push_back(r);
		endfunction

		// work out the results of one accepted transaction
		function void note_item(kind_t k, logic [11:0] pid, logic [23:0] rx,
			logic [23:0] ry, logic [23:0] rz);
			longint px, py, pz, cs, i, j, kk, h2, d2, dx, dy, dz;
			int c, s, count, first;
			bit trunc;
			px = longint'($signed(rx));
			py = longint'($signed(ry));
			pz = longint'($signed(rz));
			cs = (cell_size == 0) ? 1 : cell_size;
			// signed division truncates toward zero
			i = px / cs;
			j = py / cs;
			kk = pz / cs;
			count = 0;
			trunc = 0;
			first = pending_q.size();
			n_items++;
			case (k)
				KIND_CLEAR: begin
					foreach (fill[n]) fill[n] = 0;
					push(0, 0, ST_OK, 1);
					return;
				end
				KIND_INSERT: begin
					if (!inside_grid(i, j, kk)) begin
						n_out++;
						push(0, 0, ST_OUT, 1);
						return;
					end
					c = int'((i * SIDE + j) * SIDE + kk);
					if (fill[c] >= SLOTS) begin
						n_full++;
						push(0, 0, ST_FULL, 1);
						return;
					end
					s = c * SLOTS + fill[c];
					slot_id[s] = pid;
					slot_x[s] = px;
					slot_y[s] = py;
					slot_z[s] = pz;
					fill[c]++;
					push(0, 0, ST_OK, 1);
					return;
				end
				KIND_LIST: begin
					if (!inside_grid(i, j, kk)) begin
						n_out++;
						push(0, 0, ST_OUT, 1);
						return;
					end
					c = int'((i * SIDE + j) * SIDE + kk);
					for (int n = 0; n < fill[c]; n++) begin
						if (count < MAX_HITS) begin
							push(1, slot_id[c * SLOTS + n], ST_OK, 0);
							count++;
						end else
							trunc = 1;
					end
				end
				default: begin
					h2 = cs * cs;
					// walk x outermost, then y, then z
					for (int di = -1; di <= 1; di++)
						for (int dj = -1; dj <= 1; dj++)
							for (int dk = -1; dk <= 1; dk++) begin
								if (!inside_grid(i + di, j + dj, kk + dk))
									continue;
								c = int'(((i + di) * SIDE + j + dj) * SIDE + kk + dk);
								for (int n = 0; n < fill[c]; n++) begin
									s = c * SLOTS + n;
									if (slot_id[s] == pid)
										continue;
									dx = px - slot_x[s];
									dy = py - slot_y[s];
									dz = pz - slot_z[s];
									d2 = dx * dx + dy * dy + dz * dz;
									if (d2 >= h2)
										continue;
									if (count < MAX_HITS) begin
										push(1, slot_id[s], ST_OK, 0);
										count++;
									end else
										trunc = 1;
								end
							end
				end
			endcase
			if (count == 0) begin
				push(0, 0, ST_OK, 1);
				return;
			end
			n_hits += count;
			pending_q[first + count - 1].last = 1;
			if (trunc) begin
				n_trunc++;
				pending_q[first + count - 1].status = ST_TRUNC;
			end
		endfunction

		// compare one strobed result with the oldest expectation
		function void check_result(logic f, logic [11:0] id, logic [1:0] st, logic l);
			grid_result_t e;
			n_results++;
			if (pending_q.size() == 0) begin
				$error("unexpected result found=%0d id=%0d status=%0d last=%0d",
					f, id, st, l);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (f !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, f);
				errors++;
			end
			if (id !== e.id) begin
				$error("neighbour_id: expected %0d, got %0d", e.id, id);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        kind;
	logic [11:0]       particle_id;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [19:0]       cfg_data;
	logic              strobe;
	logic              found;
	logic [11:0]       neighbour_id;
	logic [1:0]        status;
	logic              last;

	grid_scoreboard sb;
	int             cycles;

	uniform_grid_neighbour_search_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.particle_id  (particle_id),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.found        (found),
		.neighbour_id (neighbour_id),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// every strobe is one result transaction, taken at the edge ending it
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(found, neighbour_id, status, last);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// present one item and hold it until the block takes it;
	// start is left high, the caller lowers it unless another item follows
	task automatic send_item(kind_t k, logic [11:0] pid, longint x, longint y,
		longint z);
		start <= 1'b1;
		kind <= k;
		particle_id <= pid;
		pos_x <= x[23:0];
		pos_y <= y[23:0];
		pos_z <= z[23:0];
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_item(k, pid, x[23:0], y[23:0], z[23:0]);
	endtask

	// lower start and wait until every expected result is back, then let
	// the clear sweep or any tail of work finish
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all four registers back to back, valid held high across them
	task automatic set_grid(logic [19:0] cs, logic [3:0] c, logic [3:0] r,
		logic [3:0] l);
		logic [19:0] vals[4];
		reg_idx_t    idx;
		vals[0] = cs;
		vals[1] = c;
		vals[2] = r;
		vals[3] = l;
		for (int n = 0; n < 4; n++) begin
			idx = reg_idx_t'(n);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[n];
			forever begin
				@(posedge clk);
				if (cfg_ready)
					break;
			end
			sb.set_reg(idx, vals[n]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic longint clamp24(longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	// position on one axis: mostly inside the grid, sometimes one cell beyond
	// either side, now and then anywhere in the field's range
	function automatic longint axis_pos(longint cs, int dim);
		longint cell_n;
		longint off;
		if ($urandom_range(0, 19) == 0)
			return longint'($signed(24'($urandom)));
		cell_n = longint'($urandom_range(0, dim + 1)) - 1;
		if (dim > 8)
			cell_n = (cell_n > 8) ? 8 : cell_n;
		off = longint'($urandom % 32'(cs));
		if (cell_n < 0)
			return clamp24(-off - ($urandom_range(0, 3) == 0 ? cs : 0));
		return clamp24(cell_n * cs + off);
	endfunction

	// random part of one phase: bursts with gaps, inserts dominate so that
	// cells fill up and queries have plenty to find
	task automatic random_phase(int n_items, longint cs, int dim, int max_gap);
		int     sent;
		int     burst;
		int     gap;
		int     pick;
		kind_t  k;
		logic [11:0] pid;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 10);
			for (int b = 0; b < burst && sent < n_items; b++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					k = KIND_INSERT;
				else if (pick < 78)
					k = KIND_RADIUS;
				else if (pick < 96)
					k = KIND_LIST;
				else
					k = KIND_CLEAR;
				pid = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
				send_item(k, pid, axis_pos(cs, dim), axis_pos(cs, dim),
					axis_pos(cs, dim));
				sent++;
			end
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_CLEAR;
		particle_id = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CELL_SIZE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings (cell 5120, 8x8x8)
		send_item(KIND_INSERT, 12'd1, 0, 0, 0);
		send_item(KIND_INSERT, 12'd2, 100, 200, 300);
		// negative position just above minus one cell lands in cell 0
		send_item(KIND_INSERT, 12'd3, -5119, -1, -4000);
		// same id twice: the radius query skips both
		send_item(KIND_INSERT, 12'd4, 5200, 10, 10);
		send_item(KIND_INSERT, 12'd4, 5300, 20, 20);
		send_item(KIND_INSERT, 12'hfff, 40959, 40959, 40959);
		// outside the grid on each side and at the field extremes
		send_item(KIND_INSERT, 12'd5, -5120, 0, 0);
		send_item(KIND_INSERT, 12'd6, 40960, 0, 0);
		send_item(KIND_INSERT, 12'd7, 8388607, -8388608, 8388607);
		send_item(KIND_RADIUS, 12'd4, 50, 50, 50);
		send_item(KIND_RADIUS, 12'd0, 40000, 40000, 40000);
		// radius query from a negative position that truncates into edge cell 0
		send_item(KIND_RADIUS, 12'd9, -3000, -100, -100);
		// nothing within reach
		send_item(KIND_RADIUS, 12'd9, 20000, 20000, 20000);
		send_item(KIND_LIST, 12'd0, 10, 10, 10);
		send_item(KIND_LIST, 12'd0, -8388608, 0, 0);
		send_item(KIND_LIST, 12'd0, 20000, 20000, 20000);
		send_item(KIND_CLEAR, 12'hfff, -1, -1, -1);
		send_item(KIND_LIST, 12'd0, 10, 10, 10);
		// fill one cell past its slot count, then list that cell
		for (int n = 0; n < 17; n++) begin
			send_item(KIND_INSERT, 12'(100 + n), 10 * n, 20, 30);
		end
		send_item(KIND_LIST, 12'd0, 0, 0, 0);
		drain();

		// dense 2x2x2 grid: ten inserts per cell and a truncated radius answer
		set_grid(20'd3000, 4'd2, 4'd2, 4'd2);
		random_phase(10, 3000, 2, 0);
		for (int c = 0; c < 8; c++)
			for (int n = 0; n < 10; n++)
				send_item(KIND_INSERT, 12'($urandom_range(16, 4095)),
					(c >> 2) * 3000 + 1400 + $urandom_range(0, 200),
					((c >> 1) & 1) * 3000 + 1400 + $urandom_range(0, 200),
					(c & 1) * 3000 + 1400 + $urandom_range(0, 200));
		send_item(KIND_RADIUS, 12'd0, 3000, 3000, 3000);
		random_phase(10, 3000, 2, 4);
		drain();

		// smallest cell and a one-cell grid
		set_grid(20'd1, 4'd1, 4'd1, 4'd1);
		random_phase(15, 1, 1, 6);
		drain();

		// zero cell size behaves as one, oversized grid registers saturate
		set_grid(20'd0, 4'd15, 4'd9, 4'd3);
		random_phase(15, 1, 8, 3);
		drain();

		// zero grid size: every position is outside
		set_grid(20'd700, 4'd0, 4'd4, 4'd4);
		random_phase(10, 700, 4, 2);
		drain();

		// largest cell size
		set_grid(20'hfffff, 4'd8, 4'd8, 4'd8);
		random_phase(15, 1048575, 8, 5);
		drain();

		// mid-size uneven grid, clear first
		set_grid(20'd250, 4'd3, 4'd4, 4'd2);
		send_item(KIND_CLEAR, 12'd0, 0, 0, 0);
		random_phase(40, 250, 4, 8);
		drain();

		// back to the reset settings
		set_grid(20'd5120, 4'd8, 4'd8, 4'd8);
		random_phase(25, 5120, 8, 3);
		drain();

		$display("covered %0d items, %0d results, %0d neighbours reported",
			sb.n_items, sb.n_results, sb.n_hits);
		$display("outside grid %0d, full cell %0d, truncated lists %0d",
			sb.n_out, sb.n_full, sb.n_trunc);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
